// ===== rtl/core/sfcd_pkg.sv =====
// Shared types, opcodes and constants of the serial NOR flash command decoder.
package sfcd_pkg;

   // Flash opcodes
   localparam logic [7:0] OPC_DPD    = 8'hB9;
   localparam logic [7:0] OPC_RELDPD = 8'hAB;
   localparam logic [7:0] OPC_ID     = 8'h9F;
   localparam logic [7:0] OPC_WREN   = 8'h06;
   localparam logic [7:0] OPC_STATUS = 8'h05;
   localparam logic [7:0] OPC_READ   = 8'h03;
   localparam logic [7:0] OPC_BULK   = 8'hC7;
   localparam logic [7:0] OPC_PROG   = 8'h02;
   localparam logic [7:0] OPC_SECT   = 8'h20;

   // Geometry; the page size must be a power of two
   localparam int unsigned PAGE_BYTES   = 256;
   localparam int unsigned PAGE_LOG2    = $clog2(PAGE_BYTES);
   localparam int unsigned SECTOR_BYTES = 4096;

   localparam logic [7:0] ID_MANUFACTURER = 8'hC2;
   localparam logic [7:0] ID_DEVICE_TYPE  = 8'h28;
   localparam logic [4:0] DENSITY_MAX     = 5'd24;
   localparam logic [4:0] DENSITY_RESET   = 5'd18;
   localparam logic [31:0] ADDR_RESET     = 32'hFFFF_FFFF;

   localparam int unsigned LEN_W   = 16;
   localparam int unsigned SIZE_W  = 25;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 8;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY_LOG2 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_READS  = 8'd1;

   // Transfer kinds as they arrive on the request channel
   typedef enum logic [1:0] {
      KIND_SELECT   = 2'd0,
      KIND_DESELECT = 2'd1,
      KIND_WRITE    = 2'd2,
      KIND_READ     = 2'd3
   } kind_type;

   // Decoded opcode of a write; commands with address demote to none when short
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_DPD,
      CMD_RELDPD,
      CMD_ID,
      CMD_WREN,
      CMD_STATUS,
      CMD_READ,
      CMD_PROG,
      CMD_SECT,
      CMD_BULK
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_FILL    = 3'd1,
      ACT_ID      = 3'd2,
      ACT_STATUS  = 3'd3,
      ACT_READ    = 3'd4,
      ACT_PROGRAM = 3'd5,
      ACT_ERASE   = 3'd6
   } action_type;

   typedef enum logic [4:0] {
      SS_IDLE = 5'b00001,
      SS_PROG = 5'b00010,
      SS_ID   = 5'b00100,
      SS_STAT = 5'b01000,
      SS_READ = 5'b10000
   } sub_state_type;

   // Classified request as it travels through the queue
   typedef struct packed {
      kind_type          kind;
      cmd_type           cmd;
      logic              len_zero;
      logic              len_ge3;
      logic [LEN_W-1:0]  len;
      logic [23:0]       addr24;
   } item_type;

endpackage

// ===== rtl/core/sfcd_front.sv =====
// Front end: classifies each request and pushes it into the queue.
module sfcd_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [15:0]          req_transfer_length,
   input  logic [7:0]           req_first_byte,
   input  logic [7:0]           req_addr_high_byte,
   input  logic [7:0]           req_addr_mid_byte,
   input  logic [7:0]           req_addr_low_byte,
   output logic                 push_valid,
   input  logic                 push_ready,
   output sfcd_pkg::item_type   push_item
);
   import sfcd_pkg::*;

   logic    len_ge4;
   cmd_type cmd;

   assign len_ge4 = (req_transfer_length >= 16'd4);

   always_comb begin
      case (req_first_byte)
         OPC_DPD:    cmd = CMD_DPD;
         OPC_RELDPD: cmd = CMD_RELDPD;
         OPC_ID:     cmd = CMD_ID;
         OPC_WREN:   cmd = CMD_WREN;
         OPC_STATUS: cmd = CMD_STATUS;
         OPC_READ:   cmd = len_ge4 ? CMD_READ : CMD_NONE;
         OPC_PROG:   cmd = len_ge4 ? CMD_PROG : CMD_NONE;
         OPC_SECT:   cmd = len_ge4 ? CMD_SECT : CMD_NONE;
         OPC_BULK:   cmd = CMD_BULK;
         default:    cmd = CMD_NONE;
      endcase
   end

   always_comb begin
      push_item.kind     = kind_type'(req_op);
      push_item.cmd      = cmd;
      push_item.len_zero = (req_transfer_length == 16'd0);
      push_item.len_ge3  = (req_transfer_length >= 16'd3);
      push_item.len      = req_transfer_length;
      push_item.addr24   = {req_addr_high_byte, req_addr_mid_byte, req_addr_low_byte};
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

// ===== rtl/core/sfcd_queue.sv =====
// Short queue of classified requests between front and back end.
module sfcd_queue #(
   parameter int unsigned DEPTH = sfcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  sfcd_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output sfcd_pkg::item_type  pop_item
);
   import sfcd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/sfcd_back.sv =====
// Back end: device state, configuration registers and the result register.
module sfcd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  sfcd_pkg::item_type                 pop_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_action,
   output logic [31:0]                        rsp_mem_address,
   output logic [24:0]                        rsp_mem_size,
   output logic [7:0]                         rsp_reply_byte0,
   output logic [7:0]                         rsp_reply_byte1,
   output logic [7:0]                         rsp_reply_byte2,
   output logic                               rsp_reply_valid,
   output logic                               rsp_quiet_flag
);
   import sfcd_pkg::*;

   // Device state
   sub_state_type       sub_state_ff, sub_state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                selected_ff, selected_in;
   logic                wel_ff, wel_in;
   logic                power_down_ff, power_down_in;
   logic [4:0]          density_ff;
   logic                quiet_ff;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   action_type          action_ff, action_in;
   logic [ADDR_W-1:0]   mem_address_ff, mem_address_in;
   logic [SIZE_W-1:0]   mem_size_ff, mem_size_in;
   logic [7:0]          byte0_ff, byte0_in;
   logic [7:0]          byte1_ff, byte1_in;
   logic [7:0]          byte2_ff, byte2_in;
   logic                reply_valid_ff, reply_valid_in;
   logic                quiet_flag_ff, quiet_flag_in;

   logic                take;
   logic [4:0]          bulk_log2;
   logic [PAGE_LOG2:0]  page_room;
   logic                fits_page;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign csr_ready = 1'b1;

   assign bulk_log2 = (density_ff > DENSITY_MAX) ? DENSITY_MAX : density_ff;
   assign page_room = (PAGE_LOG2 + 1)'(PAGE_BYTES)
                    - {1'b0, addr_ff[PAGE_LOG2-1:0]};
   assign fits_page = ({1'b0, pop_item.len} <= (LEN_W + 1)'(page_room));

   always_comb begin
      sub_state_in   = sub_state_ff;
      addr_in        = addr_ff;
      selected_in    = selected_ff;
      wel_in         = wel_ff;
      power_down_in  = power_down_ff;
      action_in      = ACT_NONE;
      mem_address_in = '0;
      mem_size_in    = '0;
      byte0_in       = '0;
      byte1_in       = '0;
      byte2_in       = '0;
      reply_valid_in = 1'b0;
      quiet_flag_in  = 1'b0;

      case (pop_item.kind)
         KIND_SELECT: begin
            selected_in  = 1'b1;
            sub_state_in = SS_IDLE;
         end
         KIND_DESELECT: begin
            selected_in = 1'b0;
         end
         KIND_READ: begin
            if (!selected_ff) begin
               action_in = ACT_FILL;
            end else begin
               case (sub_state_ff)
                  SS_ID: begin
                     action_in    = ACT_ID;
                     sub_state_in = SS_IDLE;
                     if (pop_item.len_ge3) begin
                        byte0_in       = ID_MANUFACTURER;
                        byte1_in       = ID_DEVICE_TYPE;
                        byte2_in       = {3'b000, density_ff};
                        reply_valid_in = 1'b1;
                     end
                  end
                  SS_STAT: begin
                     action_in = ACT_STATUS;
                     if (!pop_item.len_zero) begin
                        byte0_in       = {6'b0, wel_ff, 1'b0};
                        reply_valid_in = 1'b1;
                     end
                  end
                  SS_READ: begin
                     action_in      = ACT_READ;
                     mem_address_in = addr_ff;
                     mem_size_in    = SIZE_W'(pop_item.len);
                     quiet_flag_in  = quiet_ff;
                     addr_in        = addr_ff + ADDR_W'(pop_item.len);
                  end
                  default: begin
                     action_in = ACT_FILL;
                  end
               endcase
            end
         end
         default: begin
            // write transfer
            if (selected_ff && !pop_item.len_zero) begin
               if (sub_state_ff == SS_IDLE) begin
                  case (pop_item.cmd)
                     CMD_DPD:    power_down_in = 1'b1;
                     CMD_RELDPD: power_down_in = 1'b0;
                     CMD_ID:     sub_state_in  = SS_ID;
                     CMD_WREN:   wel_in        = 1'b1;
                     CMD_STATUS: sub_state_in  = SS_STAT;
                     CMD_READ: begin
                        addr_in      = ADDR_W'(pop_item.addr24);
                        sub_state_in = SS_READ;
                     end
                     CMD_PROG: begin
                        addr_in      = ADDR_W'(pop_item.addr24);
                        sub_state_in = SS_PROG;
                     end
                     CMD_SECT: begin
                        addr_in        = ADDR_W'(pop_item.addr24);
                        action_in      = ACT_ERASE;
                        mem_address_in = ADDR_W'(pop_item.addr24);
                        mem_size_in    = SIZE_W'(SECTOR_BYTES);
                        wel_in         = 1'b0;
                     end
                     CMD_BULK: begin
                        action_in   = ACT_ERASE;
                        mem_size_in = SIZE_W'(1) << bulk_log2;
                        wel_in      = 1'b0;
                     end
                     default: ;
                  endcase
               end else if (sub_state_ff == SS_PROG) begin
                  // program data must stay within the current page
                  if (fits_page) begin
                     action_in      = ACT_PROGRAM;
                     mem_address_in = addr_ff;
                     mem_size_in    = SIZE_W'(pop_item.len);
                     addr_in        = addr_ff + ADDR_W'(pop_item.len);
                     wel_in         = 1'b0;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_state_ff  <= SS_IDLE;
         addr_ff       <= ADDR_RESET;
         selected_ff   <= 1'b0;
         wel_ff        <= 1'b0;
         power_down_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            sub_state_ff  <= sub_state_in;
            addr_ff       <= addr_in;
            selected_ff   <= selected_in;
            wel_ff        <= wel_in;
            power_down_ff <= power_down_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= DENSITY_RESET;
         quiet_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DENSITY_LOG2) begin
            density_ff <= csr_wdata[4:0];
         end else if (csr_index == CSR_QUIET_READS) begin
            quiet_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff      <= action_in;
         mem_address_ff <= mem_address_in;
         mem_size_ff    <= mem_size_in;
         byte0_ff       <= byte0_in;
         byte1_ff       <= byte1_in;
         byte2_ff       <= byte2_in;
         reply_valid_ff <= reply_valid_in;
         quiet_flag_ff  <= quiet_flag_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_mem_address = mem_address_ff;
   assign rsp_mem_size    = mem_size_ff;
   assign rsp_reply_byte0 = byte0_ff;
   assign rsp_reply_byte1 = byte1_ff;
   assign rsp_reply_byte2 = byte2_ff;
   assign rsp_reply_valid = reply_valid_ff;
   assign rsp_quiet_flag  = quiet_flag_ff;

endmodule

// ===== rtl/core/spi_nor_flash_command_decoder_top.sv =====
// Top level of the serial NOR flash command decoder.
//
//  channel   ports   direction  carries
//  request   req_*   in         one SPI transfer: op, length, first four bytes
//  response  rsp_*   out        one action per transfer with address, size, reply
//  csr       csr_*   in         register index and write data
//
// One request per clock sustained while responses are taken; a request's response
// comes from the result register of the back end, after a pass through the queue.
// The front classifies requests into a queue of QUEUE_DEPTH entries; the back
// end holds the device state and takes one queued request per cycle whenever
// its result register is empty or being read. Response stalls fill the queue
// and then drop req_ready. Reset is synchronous; no clearing pass.
module spi_nor_flash_command_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [15:0]                        req_transfer_length,
   input  logic [7:0]                         req_first_byte,
   input  logic [7:0]                         req_addr_high_byte,
   input  logic [7:0]                         req_addr_mid_byte,
   input  logic [7:0]                         req_addr_low_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_action,
   output logic [31:0]                        rsp_mem_address,
   output logic [24:0]                        rsp_mem_size,
   output logic [7:0]                         rsp_reply_byte0,
   output logic [7:0]                         rsp_reply_byte1,
   output logic [7:0]                         rsp_reply_byte2,
   output logic                               rsp_reply_valid,
   output logic                               rsp_quiet_flag,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfcd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sfcd_pkg::*;

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   sfcd_front u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_transfer_length (req_transfer_length),
      .req_first_byte      (req_first_byte),
      .req_addr_high_byte  (req_addr_high_byte),
      .req_addr_mid_byte   (req_addr_mid_byte),
      .req_addr_low_byte   (req_addr_low_byte),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_item           (push_item)
   );

   sfcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sfcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_mem_address (rsp_mem_address),
      .rsp_mem_size    (rsp_mem_size),
      .rsp_reply_byte0 (rsp_reply_byte0),
      .rsp_reply_byte1 (rsp_reply_byte1),
      .rsp_reply_byte2 (rsp_reply_byte2),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_quiet_flag  (rsp_quiet_flag)
   );

endmodule

// ===== sim/tb_spi_nor_flash_command_decoder_top.sv =====
// Self-checking testbench of the serial NOR flash command decoder.
module tb_spi_nor_flash_command_decoder_top;
   import sfcd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PHASE_REQUESTS = 340;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNMAPPED = 8'hFE;
   localparam logic [7:0] FLASH_OPCODES [9] = '{OPC_DPD, OPC_RELDPD, OPC_ID, OPC_WREN,
      OPC_STATUS, OPC_READ, OPC_BULK, OPC_PROG, OPC_SECT};

   typedef struct {
      kind_type    op;
      logic [15:0] length;
      logic [7:0]  opcode;
      logic [23:0] address;
   } spi_transfer_type;

   typedef struct {
      action_type  action;
      logic [31:0] address;
      logic [24:0] size;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic        reply_ok;
      logic        quiet;
   } flash_action_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [15:0] req_transfer_length = '0;
   logic [7:0]  req_first_byte = '0;
   logic [7:0]  req_addr_high_byte = '0;
   logic [7:0]  req_addr_mid_byte = '0;
   logic [7:0]  req_addr_low_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_mem_address;
   logic [24:0] rsp_mem_size;
   logic [7:0]  rsp_reply_byte0;
   logic [7:0]  rsp_reply_byte1;
   logic [7:0]  rsp_reply_byte2;
   logic        rsp_reply_valid;
   logic        rsp_quiet_flag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted device state and configuration
   sub_state_type flash_state;
   logic [31:0]   flash_address;
   logic          flash_selected;
   logic          flash_wel;
   logic          flash_power_down;
   logic [4:0]    density_cfg;
   logic          quiet_cfg;

   spi_transfer_type pending_transfers [$];
   flash_action_type expected_actions [$];
   int unsigned   requests_queued = 0;
   int unsigned   requests_accepted = 0;
   int unsigned   actions_checked = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   req_idle_pct = 29;
   int unsigned   rsp_idle_pct = 29;

   spi_nor_flash_command_decoder_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_transfer_length (req_transfer_length),
      .req_first_byte      (req_first_byte),
      .req_addr_high_byte  (req_addr_high_byte),
      .req_addr_mid_byte   (req_addr_mid_byte),
      .req_addr_low_byte   (req_addr_low_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_action          (rsp_action),
      .rsp_mem_address     (rsp_mem_address),
      .rsp_mem_size        (rsp_mem_size),
      .rsp_reply_byte0     (rsp_reply_byte0),
      .rsp_reply_byte1     (rsp_reply_byte1),
      .rsp_reply_byte2     (rsp_reply_byte2),
      .rsp_reply_valid     (rsp_reply_valid),
      .rsp_quiet_flag      (rsp_quiet_flag),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one transfer to the predicted device state, returns the action it yields.
   function automatic flash_action_type decode_transfer(input spi_transfer_type t);
      flash_action_type act;
      logic [31:0]   room;
      logic [4:0]    bulk_log2;
      act = '{ACT_NONE, 32'd0, 25'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
      case (t.op)
         KIND_SELECT: begin
            flash_selected = 1'b1;
            flash_state = SS_IDLE;
         end
         KIND_DESELECT: flash_selected = 1'b0;
         KIND_READ: begin
            if (!flash_selected || flash_state == SS_IDLE || flash_state == SS_PROG) begin
               act.action = ACT_FILL;
            end else if (flash_state == SS_ID) begin
               act.action = ACT_ID;
               if (t.length >= 16'd3) begin
                  act.byte0 = ID_MANUFACTURER;
                  act.byte1 = ID_DEVICE_TYPE;
                  act.byte2 = {3'b000, density_cfg};
                  act.reply_ok = 1'b1;
               end
               flash_state = SS_IDLE;
            end else if (flash_state == SS_STAT) begin
               act.action = ACT_STATUS;
               if (t.length != 16'd0) begin
                  act.byte0 = {6'd0, flash_wel, 1'b0};
                  act.reply_ok = 1'b1;
               end
            end else begin
               act.action = ACT_READ;
               act.address = flash_address;
               act.size = 25'(t.length);
               act.quiet = quiet_cfg;
               flash_address = flash_address + 32'(t.length);
            end
         end
         default: begin
            if (flash_selected && t.length != 16'd0) begin
               if (flash_state == SS_IDLE) begin
                  case (t.opcode)
                     OPC_DPD:    flash_power_down = 1'b1;
                     OPC_RELDPD: flash_power_down = 1'b0;
                     OPC_ID:     flash_state = SS_ID;
                     OPC_WREN:   flash_wel = 1'b1;
                     OPC_STATUS: flash_state = SS_STAT;
                     OPC_READ: begin
                        if (t.length >= 16'd4) begin
                           flash_address = 32'(t.address);
                           flash_state = SS_READ;
                        end
                     end
                     OPC_PROG: begin
                        if (t.length >= 16'd4) begin
                           flash_address = 32'(t.address);
                           flash_state = SS_PROG;
                        end
                     end
                     OPC_SECT: begin
                        if (t.length >= 16'd4) begin
                           flash_address = 32'(t.address);
                           act.action = ACT_ERASE;
                           act.address = 32'(t.address);
                           act.size = 25'(SECTOR_BYTES);
                           flash_wel = 1'b0;
                        end
                     end
                     OPC_BULK: begin
                        bulk_log2 = (density_cfg > DENSITY_MAX) ? DENSITY_MAX : density_cfg;
                        act.action = ACT_ERASE;
                        act.size = 25'd1 << bulk_log2;
                        flash_wel = 1'b0;
                     end
                     default: ;
                  endcase
               end else if (flash_state == SS_PROG) begin
                  room = 32'(PAGE_BYTES) - (flash_address % 32'(PAGE_BYTES));
                  if (32'(t.length) <= room) begin
                     act.action = ACT_PROGRAM;
                     act.address = flash_address;
                     act.size = 25'(t.length);
                     flash_address = flash_address + 32'(t.length);
                     flash_wel = 1'b0;
                  end
               end
            end
         end
      endcase
      return act;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin : driver
      spi_transfer_type seen;
      spi_transfer_type next_xfer;
      if (reset) begin
         req_valid <= 1'b0;
         flash_state = SS_IDLE;
         flash_address = ADDR_RESET;
         flash_selected = 1'b0;
         flash_wel = 1'b0;
         flash_power_down = 1'b0;
         density_cfg = DENSITY_RESET;
         quiet_cfg = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            seen.op = kind_type'(req_op);
            seen.length = req_transfer_length;
            seen.opcode = req_first_byte;
            seen.address = {req_addr_high_byte, req_addr_mid_byte, req_addr_low_byte};
            expected_actions.push_back(decode_transfer(seen));
            requests_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_transfers.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               next_xfer = pending_transfers.pop_front();
               req_valid <= 1'b1;
               req_op <= next_xfer.op;
               req_transfer_length <= next_xfer.length;
               req_first_byte <= next_xfer.opcode;
               req_addr_high_byte <= next_xfer.address[23:16];
               req_addr_mid_byte <= next_xfer.address[15:8];
               req_addr_low_byte <= next_xfer.address[7:0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor; holds off twice for a long stretch to back up the queue
   always @(posedge clock) begin : monitor
      int unsigned   hold_left;
      flash_action_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_actions.size() == 0) begin
               $error("action: unexpected response 0x%0h", rsp_action);
               mismatch_count++;
            end else begin
               want = expected_actions.pop_front();
               compare_field("action", want.action, rsp_action);
               compare_field("mem_address", want.address, rsp_mem_address);
               compare_field("mem_size", want.size, rsp_mem_size);
               compare_field("reply_byte0", want.byte0, rsp_reply_byte0);
               compare_field("reply_byte1", want.byte1, rsp_reply_byte1);
               compare_field("reply_byte2", want.byte2, rsp_reply_byte2);
               compare_field("reply_valid", want.reply_ok, rsp_reply_valid);
               compare_field("quiet_flag", want.quiet, rsp_quiet_flag);
            end
            actions_checked++;
            if (actions_checked == 300 || actions_checked == 1200) hold_left = 120;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_request(input kind_type op, input logic [15:0] length,
                                input logic [7:0] opcode, input logic [23:0] address);
      pending_transfers.push_back('{op, length, opcode, address});
      requests_queued++;
   endtask

   function automatic logic [15:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 16'($urandom_range(8));
      if (r < 80) return 16'($urandom_range(300, 9));
      if (r < 90) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_payload_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) return 16'($urandom_range(64, 1));
      if (r < 75) return 16'($urandom_range(300, 200));
      if (r < 90) return 16'(PAGE_BYTES);
      return pick_length();
   endfunction

   // select, one command with random content, its follow-up transfers, mostly a deselect
   task automatic queue_command_sequence();
      logic [23:0] addr;
      int unsigned n;
      addr = 24'($urandom);
      n = $urandom_range(4, 1);
      queue_request(KIND_SELECT, 16'($urandom), 8'($urandom), 24'($urandom));
      case ($urandom_range(8))
         0: begin
            queue_request(KIND_WRITE, 16'($urandom_range(4, 1)), OPC_ID, addr);
            queue_request(KIND_READ, 16'($urandom_range(5)), 8'($urandom), addr);
         end
         1: begin
            queue_request(KIND_WRITE, 16'($urandom_range(4, 1)), OPC_STATUS, addr);
            repeat (n) queue_request(KIND_READ, 16'($urandom_range(3)), 8'($urandom), addr);
         end
         2: begin
            queue_request(KIND_WRITE, 16'($urandom_range(8, 3)), OPC_READ, addr);
            repeat (n) queue_request(KIND_READ, pick_length(), 8'($urandom), addr);
         end
         3: begin
            queue_request(KIND_WRITE, 16'($urandom_range(8, 3)), OPC_PROG, addr);
            repeat (n) begin
               if ($urandom_range(9) == 0)
                  queue_request(KIND_READ, pick_length(), 8'($urandom), addr);
               else
                  queue_request(KIND_WRITE, pick_payload_length(), 8'($urandom), 24'($urandom));
            end
         end
         4: queue_request(KIND_WRITE, 16'($urandom_range(6, 3)), OPC_SECT, addr);
         5: queue_request(KIND_WRITE, pick_length(), OPC_BULK, addr);
         6: begin
            queue_request(KIND_WRITE, 16'($urandom_range(4, 1)), OPC_WREN, addr);
            queue_request(KIND_WRITE, 16'($urandom_range(4, 1)), OPC_STATUS, addr);
            queue_request(KIND_READ, 16'($urandom_range(3)), 8'($urandom), addr);
         end
         7: queue_request(KIND_WRITE, 16'($urandom_range(4, 1)),
                          $urandom_range(1) ? OPC_DPD : OPC_RELDPD, addr);
         default: begin
            // writes while in the ID state are dropped
            queue_request(KIND_WRITE, 16'($urandom_range(4, 1)), OPC_ID, addr);
            queue_request(KIND_WRITE, pick_length(), FLASH_OPCODES[$urandom_range(8)], addr);
            queue_request(KIND_READ, 16'($urandom_range(5)), 8'($urandom), addr);
         end
      endcase
      if ($urandom_range(3) != 0)
         queue_request(KIND_DESELECT, 16'($urandom), 8'($urandom), 24'($urandom));
   endtask

   task automatic queue_noise();
      logic [7:0] opcode;
      opcode = $urandom_range(1) ? FLASH_OPCODES[$urandom_range(8)] : 8'($urandom);
      queue_request(kind_type'($urandom_range(3)), pick_length(), opcode, 24'($urandom));
   endtask

   task automatic wait_idle();
      while (requests_accepted != requests_queued || expected_actions.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DENSITY_LOG2) density_cfg = data[4:0];
      else if (idx == CSR_QUIET_READS) quiet_cfg = data[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] density_wdata [5];
      logic [CSR_DATA_W-1:0] quiet_wdata [5];
      density_wdata = '{8'd18, 8'd13, 8'd24, 8'hFF, 8'hE0};
      quiet_wdata = '{8'd0, 8'd1, 8'd0, 8'hFF, 8'hFE};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unselected, empty write, short ID read, status repeat, short command
      queue_request(KIND_READ, 16'd1, 8'h00, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, OPC_WREN, 24'hFFFFFF);
      queue_request(KIND_SELECT, 16'hFFFF, 8'hFF, 24'hFFFFFF);
      queue_request(KIND_WRITE, 16'd0, OPC_WREN, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, OPC_ID, 24'h000000);
      queue_request(KIND_READ, 16'd2, 8'h00, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, OPC_ID, 24'h000000);
      queue_request(KIND_READ, 16'hFFFF, 8'hFF, 24'hFFFFFF);
      queue_request(KIND_WRITE, 16'd1, OPC_WREN, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, OPC_STATUS, 24'h000000);
      queue_request(KIND_READ, 16'd1, 8'h00, 24'h000000);
      queue_request(KIND_READ, 16'd0, 8'h00, 24'h000000);
      queue_request(KIND_SELECT, 16'd0, 8'h00, 24'h000000);
      queue_request(KIND_WRITE, 16'd3, OPC_READ, 24'h123456);
      queue_request(KIND_WRITE, 16'd4, OPC_READ, 24'hFFFFFF);
      queue_request(KIND_READ, 16'd0, 8'h00, 24'h000000);
      queue_request(KIND_READ, 16'hFFFF, 8'h00, 24'h000000);
      // page crossing, then a fitting program and a read in the program state
      queue_request(KIND_SELECT, 16'd0, 8'h00, 24'h000000);
      queue_request(KIND_WRITE, 16'd4, OPC_PROG, 24'h0000F0);
      queue_request(KIND_WRITE, 16'd17, 8'hA5, 24'h000000);
      queue_request(KIND_WRITE, 16'd16, 8'h5A, 24'h000000);
      queue_request(KIND_READ, 16'd1, 8'h00, 24'h000000);
      queue_request(KIND_SELECT, 16'd0, 8'h00, 24'h000000);
      queue_request(KIND_WRITE, 16'd4, OPC_SECT, 24'h123456);
      queue_request(KIND_WRITE, 16'd1, OPC_BULK, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, OPC_DPD, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, OPC_RELDPD, 24'h000000);
      queue_request(KIND_WRITE, 16'd1, 8'hFF, 24'h000000);
      queue_request(KIND_DESELECT, 16'd0, 8'h00, 24'h000000);

      for (int phase = 0; phase < 5; phase++) begin
         if (phase != 0) begin
            wait_idle();
            write_csr(CSR_DENSITY_LOG2, density_wdata[phase]);
            write_csr(CSR_QUIET_READS, quiet_wdata[phase]);
            if (phase == 3) write_csr(CSR_INDEX_UNMAPPED, 8'($urandom));
         end
         req_idle_pct = (phase == 2) ? 0 : 29;
         rsp_idle_pct = (phase == 2) ? 0 : 29;
         while (requests_queued < (phase + 1) * PHASE_REQUESTS) begin
            if ($urandom_range(99) < 80) queue_command_sequence();
            else queue_noise();
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
